>>> hdl/scdm_pkg.sv
package scdm_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DIGITS    = 4;
    localparam int LINE_LEN  = 16;

    localparam int ITEM_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int LEN_W   = $clog2(LINE_LEN);
    localparam int FIELD_W = 16;
    localparam int FNUM_W  = 3;
    localparam int DIG_W   = 2;
    localparam int VAL_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
    localparam logic [FNUM_W-1:0]  FNUM_MAX  = '1;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [FIELD_W:0] DIV10_MUL   = 17'd52429;
    localparam int               DIV10_SHIFT = 19;

    localparam int BANNER_LEN = 10;
    localparam int BIDX_W     = $clog2(BANNER_LEN);

    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
    localparam logic [BYTE_W-1:0] CH_V     = 8'h56;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_DIGIT = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_BANNER = 3'd1,
        OP_SET    = 3'd2,
        OP_RATE   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
    } t_cmd;

    function automatic logic [BYTE_W-1:0] banner_char(input logic [BIDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h44;
            4'd1:    c = 8'h55;
            4'd2:    c = 8'h4D;
            4'd3:    c = 8'h42;
            4'd4:    c = 8'h6F;
            4'd5:    c = 8'h20;
            4'd6:    c = 8'h56;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h0D;
            4'd9:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/scdm_if.sv
interface scdm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [scdm_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface scdm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [scdm_pkg::BYTE_W-1:0]  tx_byte;
    logic [scdm_pkg::DIG_W-1:0]   digit_position;
    logic [scdm_pkg::VAL_W-1:0]   digit_value;
    logic                         last;

    modport source (output valid, output kind, output tx_byte, output digit_position,
                    output digit_value, output last, input ready);
    modport sink   (input valid, input kind, input tx_byte, input digit_position,
                    input digit_value, input last, output ready);
endinterface

>>> hdl/scdm_ram.sv
module scdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/scdm_front.sv
module scdm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scdm_in_if.sink          i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output scdm_pkg::t_cmd   o_cmd
);

    logic [scdm_pkg::LEN_W-1:0]   r_line_len, n_line_len;
    logic [scdm_pkg::BYTE_W-1:0]  r_letter, n_letter;
    logic [scdm_pkg::FNUM_W-1:0]  r_fnum, n_fnum;
    logic [scdm_pkg::FIELD_W-1:0] r_acc, n_acc;
    logic [scdm_pkg::FIELD_W-1:0] r_entry, n_entry;
    logic [scdm_pkg::FIELD_W-1:0] r_value, n_value;

    logic                         take;
    logic [scdm_pkg::FIELD_W-1:0] eff_entry;
    logic [scdm_pkg::FIELD_W-1:0] eff_value;
    logic [scdm_pkg::FIELD_W+3:0] acc_ext;
    logic [scdm_pkg::FIELD_W+3:0] acc_next;

    assign i_in.ready = !i_q_full;
    assign take       = i_in.valid && i_in.ready;

    // a newline closes the open field before the command runs
    assign eff_entry = (r_fnum == '0) ? r_acc : r_entry;
    assign eff_value = (r_fnum == scdm_pkg::FNUM_W'(1)) ? r_acc : r_value;

    assign acc_ext  = {4'b0, r_acc};
    assign acc_next = (acc_ext << 3) + (acc_ext << 1)
                    + {(scdm_pkg::FIELD_W+4-scdm_pkg::VAL_W)'(0),
                       i_in.rx_byte[scdm_pkg::VAL_W-1:0]};

    always_comb begin
        n_line_len = r_line_len;
        n_letter   = r_letter;
        n_fnum     = r_fnum;
        n_acc      = r_acc;
        n_entry    = r_entry;
        n_value    = r_value;
        o_push     = 1'b0;
        o_cmd.op   = scdm_pkg::OP_TICK;
        o_cmd.a    = '0;
        o_cmd.b    = '0;

        if (take) begin
            if (i_in.action) begin
                o_push = 1'b1;
            end else if (i_in.rx_byte == scdm_pkg::CH_NL) begin
                case (r_letter)
                    scdm_pkg::CH_QUERY: begin
                        o_push   = 1'b1;
                        o_cmd.op = scdm_pkg::OP_BANNER;
                    end
                    scdm_pkg::CH_S: begin
                        o_push   = 1'b1;
                        o_cmd.op = scdm_pkg::OP_SET;
                        o_cmd.a  = (eff_entry > scdm_pkg::FIELD_W'(scdm_pkg::MAX_ITEMS))
                                 ? scdm_pkg::FIELD_W'(scdm_pkg::MAX_ITEMS) : eff_entry;
                    end
                    scdm_pkg::CH_I: begin
                        o_push   = 1'b1;
                        o_cmd.op = scdm_pkg::OP_RATE;
                        o_cmd.a  = eff_entry;
                    end
                    scdm_pkg::CH_V: begin
                        o_push   = 1'b1;
                        o_cmd.op = scdm_pkg::OP_WRITE;
                        o_cmd.a  = eff_entry;
                        o_cmd.b  = eff_value;
                    end
                    default: begin
                    end
                endcase
                n_line_len = '0;
                n_letter   = '0;
                n_fnum     = '0;
                n_acc      = '0;
                n_entry    = '0;
                n_value    = '0;
            end else if (r_line_len < scdm_pkg::LEN_W'(scdm_pkg::LINE_LEN - 1)) begin
                n_line_len = r_line_len + 1'b1;
                if (r_line_len == '0) begin
                    n_letter = i_in.rx_byte;
                end else if (i_in.rx_byte inside {[scdm_pkg::CH_ZERO:scdm_pkg::CH_NINE]}) begin
                    n_acc = (acc_next > (scdm_pkg::FIELD_W+4)'(scdm_pkg::FIELD_MAX))
                          ? scdm_pkg::FIELD_MAX : acc_next[scdm_pkg::FIELD_W-1:0];
                end else begin
                    // any other character ends the field
                    if (r_fnum == '0) begin
                        n_entry = r_acc;
                    end else if (r_fnum == scdm_pkg::FNUM_W'(1)) begin
                        n_value = r_acc;
                    end
                    if (r_fnum != scdm_pkg::FNUM_MAX) begin
                        n_fnum = r_fnum + 1'b1;
                    end
                    n_acc = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_letter   <= '0;
            r_fnum     <= '0;
            r_acc      <= '0;
            r_entry    <= '0;
            r_value    <= '0;
        end else begin
            r_line_len <= n_line_len;
            r_letter   <= n_letter;
            r_fnum     <= n_fnum;
            r_acc      <= n_acc;
            r_entry    <= n_entry;
            r_value    <= n_value;
        end
    end

endmodule

>>> hdl/scdm_queue.sv
module scdm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scdm_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output scdm_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);

    scdm_pkg::t_cmd              r_mem [scdm_pkg::QDEPTH];
    logic [scdm_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [scdm_pkg::QPTR_W:0]   r_cnt;
    logic                        do_push, do_pop;

    assign o_full  = (r_cnt == (scdm_pkg::QPTR_W+1)'(scdm_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/scdm_back.sv
module scdm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  scdm_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    scdm_out_if.source       o_out
);

    typedef enum logic [2:0] {
        ST_RUN    = 3'b001,
        ST_BANNER = 3'b010,
        ST_LOAD   = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_active, n_active;
    logic [scdm_pkg::CNT_W-1:0]   r_count, n_count;
    logic [scdm_pkg::FIELD_W-1:0] r_wait, n_wait;
    logic [scdm_pkg::FIELD_W-1:0] r_shift, n_shift;
    logic [scdm_pkg::DIG_W-1:0]   r_dig, n_dig;
    logic [scdm_pkg::FIELD_W-1:0] r_rep, n_rep;
    logic [scdm_pkg::ITEM_W-1:0]  r_shown, n_shown;
    logic [scdm_pkg::MAX_ITEMS-1:0] r_vld, n_vld;
    logic                         r_rd_vld, n_rd_vld;
    logic [scdm_pkg::BIDX_W-1:0]  r_bcnt, n_bcnt;

    logic                         r_out_valid;
    logic                         r_kind;
    logic [scdm_pkg::BYTE_W-1:0]  r_tx;
    logic [scdm_pkg::DIG_W-1:0]   r_pos;
    logic [scdm_pkg::VAL_W-1:0]   r_val;
    logic                         r_last;

    logic                         out_free;
    logic                         emit;
    logic                         e_kind;
    logic [scdm_pkg::BYTE_W-1:0]  e_tx;
    logic [scdm_pkg::DIG_W-1:0]   e_pos;
    logic [scdm_pkg::VAL_W-1:0]   e_val;
    logic                         e_last;

    logic [scdm_pkg::FIELD_W+scdm_pkg::DIV10_SHIFT-1:0] prod;
    logic [scdm_pkg::FIELD_W-1:0] quot;
    logic [scdm_pkg::FIELD_W-1:0] rem;
    logic [scdm_pkg::FIELD_W-1:0] rep_inc;
    logic [scdm_pkg::ITEM_W:0]    shown_inc;

    logic                         ram_we;
    logic [scdm_pkg::ITEM_W-1:0]  ram_raddr;
    logic [scdm_pkg::FIELD_W-1:0] ram_q;

    // shift_value split into quotient and low decimal digit
    assign prod    = (scdm_pkg::FIELD_W+scdm_pkg::DIV10_SHIFT)'(r_shift)
                   * (scdm_pkg::FIELD_W+scdm_pkg::DIV10_SHIFT)'(scdm_pkg::DIV10_MUL);
    assign quot    = prod[scdm_pkg::DIV10_SHIFT +: scdm_pkg::FIELD_W];
    assign rem     = r_shift - ((quot << 3) + (quot << 1));
    assign rep_inc = r_rep + 1'b1;
    assign shown_inc = {1'b0, r_shown} + 1'b1;

    assign out_free = !r_out_valid || o_out.ready;

    scdm_ram #(
        .WIDTH (scdm_pkg::FIELD_W),
        .DEPTH (scdm_pkg::MAX_ITEMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.a[scdm_pkg::ITEM_W-1:0]),
        .i_wdata (i_cmd.b),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_count  = r_count;
        n_wait   = r_wait;
        n_shift  = r_shift;
        n_dig    = r_dig;
        n_rep    = r_rep;
        n_shown  = r_shown;
        n_vld    = r_vld;
        n_rd_vld = r_rd_vld;
        n_bcnt   = r_bcnt;
        o_pop    = 1'b0;
        emit     = 1'b0;
        e_kind   = scdm_pkg::KIND_TX;
        e_tx     = '0;
        e_pos    = '0;
        e_val    = '0;
        e_last   = 1'b0;
        ram_we   = 1'b0;
        ram_raddr = r_shown;

        case (r_state)
            ST_RUN: begin
                if (i_q_valid) begin
                    case (i_cmd.op)
                        scdm_pkg::OP_TICK: begin
                            if (!r_active) begin
                                o_pop = 1'b1;
                            end else if (out_free) begin
                                o_pop   = 1'b1;
                                emit    = 1'b1;
                                e_kind  = scdm_pkg::KIND_DIGIT;
                                e_pos   = r_dig;
                                e_val   = rem[scdm_pkg::VAL_W-1:0];
                                e_last  = 1'b1;
                                n_shift = quot;
                                if (r_dig == scdm_pkg::DIG_W'(scdm_pkg::DIGITS - 1)) begin
                                    n_dig = '0;
                                    if (rep_inc >= r_wait) begin
                                        n_rep = '0;
                                        if ((scdm_pkg::FIELD_W'(shown_inc)
                                                >= scdm_pkg::FIELD_W'(r_count))
                                            || (scdm_pkg::FIELD_W'(shown_inc)
                                                >= scdm_pkg::FIELD_W'(scdm_pkg::MAX_ITEMS))) begin
                                            n_shown = '0;
                                        end else begin
                                            n_shown = shown_inc[scdm_pkg::ITEM_W-1:0];
                                        end
                                    end else begin
                                        n_rep = rep_inc;
                                    end
                                    // fetch the next value; it lands next cycle
                                    ram_raddr = n_shown;
                                    n_rd_vld  = r_vld[n_shown];
                                    n_state   = ST_LOAD;
                                end else begin
                                    n_dig = r_dig + 1'b1;
                                end
                            end
                        end
                        scdm_pkg::OP_BANNER: begin
                            o_pop   = 1'b1;
                            n_bcnt  = '0;
                            n_state = ST_BANNER;
                        end
                        scdm_pkg::OP_SET: begin
                            o_pop    = 1'b1;
                            n_count  = i_cmd.a[scdm_pkg::CNT_W-1:0];
                            n_vld    = '0;
                            n_active = 1'b1;
                        end
                        scdm_pkg::OP_RATE: begin
                            o_pop  = 1'b1;
                            n_wait = i_cmd.a;
                        end
                        scdm_pkg::OP_WRITE: begin
                            o_pop = 1'b1;
                            if (i_cmd.a < scdm_pkg::FIELD_W'(r_count)) begin
                                ram_we = 1'b1;
                                n_vld[i_cmd.a[scdm_pkg::ITEM_W-1:0]] = 1'b1;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_BANNER: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = scdm_pkg::KIND_TX;
                    e_tx   = scdm_pkg::banner_char(r_bcnt);
                    e_last = (r_bcnt == scdm_pkg::BIDX_W'(scdm_pkg::BANNER_LEN - 1));
                    if (e_last) begin
                        n_state = ST_RUN;
                    end else begin
                        n_bcnt = r_bcnt + 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                n_shift = r_rd_vld ? ram_q : '0;
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_active    <= 1'b0;
            r_count     <= '0;
            r_wait      <= scdm_pkg::FIELD_W'(1);
            r_shift     <= '0;
            r_dig       <= '0;
            r_rep       <= '0;
            r_shown     <= '0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_bcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_count  <= n_count;
            r_wait   <= n_wait;
            r_shift  <= n_shift;
            r_dig    <= n_dig;
            r_rep    <= n_rep;
            r_shown  <= n_shown;
            r_vld    <= n_vld;
            r_rd_vld <= n_rd_vld;
            r_bcnt   <= n_bcnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= e_kind;
            r_tx   <= e_tx;
            r_pos  <= e_pos;
            r_val  <= e_val;
            r_last <= e_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.tx_byte        = r_tx;
    assign o_out.digit_position = r_pos;
    assign o_out.digit_value    = r_val;
    assign o_out.last           = r_last;

endmodule

>>> hdl/serial_command_digit_multiplexer.sv
// Flow: an accepted tick goes through the command queue to the output register; a '?' line
//   goes through the queue, then shows its banner one item per cycle while not stalled.
// Throughput: one input item per cycle unless the command queue is full; a tick ending a
//   digit sweep adds the ST_LOAD table read, and the back end stays in a banner to its end.
// Reset (synchronous, active low): all control state cleared, repeat limit set to one,
//   table valid bits cleared so every entry reads zero; no clearing pass is needed.
module serial_command_digit_multiplexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scdm_in_if.sink     i_in,
    scdm_out_if.source  o_out
);

    // Front end: line assembly and field parsing. Each accepted item is classified at once;
    // ticks and completed command lines with a known letter become one queued command, other bytes only update
    // the line state. The front stalls only when the command queue is full.
    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    scdm_pkg::t_cmd q_in_cmd;
    scdm_pkg::t_cmd q_out_cmd;

    scdm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in_cmd)
    );

    // Short command queue so the parser keeps taking bytes while the back end is busy
    // with a banner burst or a stalled output.
    scdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    // Back end: display table (RAM + per-entry valid bits), digit multiplexing counters,
    // banner sequencer and the output register. A new result is loaded whenever the
    // output register is empty or being drained in the same cycle.
    scdm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_out_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

>>> hdl/scdm_checker.sv
module scdm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_kind,
    input logic [scdm_pkg::BYTE_W-1:0] i_out_tx_byte,
    input logic [scdm_pkg::DIG_W-1:0]  i_out_digit_position,
    input logic [scdm_pkg::VAL_W-1:0]  i_out_digit_value,
    input logic                        i_out_last
);

    // digit items are single results with a decimal value
    a_digit_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == scdm_pkg::KIND_DIGIT)
        |-> (i_out_last && i_out_digit_value <= scdm_pkg::VAL_W'(9) && i_out_tx_byte == '0))
        else $error("bad digit item");

    // banner burst is not interrupted
    a_banner_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_kind == scdm_pkg::KIND_TX && !i_out_last)
        |=> (i_out_valid && i_out_kind == scdm_pkg::KIND_TX))
        else $error("banner burst broken");

    // banner closes with line feed
    a_banner_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == scdm_pkg::KIND_TX && i_out_last)
        |-> (i_out_tx_byte == scdm_pkg::CH_NL && i_out_digit_position == '0))
        else $error("banner end wrong");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_kind) && $stable(i_out_tx_byte)
             && $stable(i_out_digit_value) && $stable(i_out_last)))
        else $error("stalled item changed");

endmodule

bind serial_command_digit_multiplexer scdm_checker u_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_kind           (o_out.kind),
    .i_out_tx_byte        (o_out.tx_byte),
    .i_out_digit_position (o_out.digit_position),
    .i_out_digit_value    (o_out.digit_value),
    .i_out_last           (o_out.last)
);
